/* hdl/rpn_pkg.sv */
// rpn_pkg: shared widths, action and status codes and sequencer states
// for the postfix stack evaluator
// no dependencies

package rpn_pkg;

    // field and port widths
    localparam int VALUE_W     = 32;
    localparam int COUNT_W     = 7;
    localparam int ACTION_W    = 3;
    localparam int STATUS_W    = 3;
    localparam int STEP_W      = 5;
    localparam int ADDER_W     = VALUE_W + 1;

    // last iteration of the bit-serial multiply and divide
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(VALUE_W - 1);

    typedef logic [VALUE_W-1:0]  t_value;
    typedef logic [COUNT_W-1:0]  t_count;
    typedef logic [ACTION_W-1:0] t_action;
    typedef logic [STATUS_W-1:0] t_status;

    // action codes
    localparam t_action ACT_PUSH = 3'd0;
    localparam t_action ACT_ADD  = 3'd1;
    localparam t_action ACT_SUB  = 3'd2;
    localparam t_action ACT_MUL  = 3'd3;
    localparam t_action ACT_DIV  = 3'd4;
    localparam t_action ACT_DUMP = 3'd5;

    // status codes
    localparam t_status STAT_OK       = 3'd0;
    localparam t_status STAT_OVERFLOW = 3'd1;
    localparam t_status STAT_UNDERFLOW = 3'd2;
    localparam t_status STAT_DIVZERO  = 3'd3;
    localparam t_status STAT_HALTED   = 3'd4;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OPER,
        ST_MUL,
        ST_DIV,
        ST_DIV_FIX,
        ST_PUSH_RES,
        ST_ZREAD,
        ST_ZTOP,
        ST_EMIT,
        ST_DUMP_RD,
        ST_DUMP_EMIT
    } t_state;

endpackage

/* hdl/rpn_stack_evaluator.sv */
// rpn_stack_evaluator: postfix integer evaluator on a bounded stack, with one shared
// 33-bit adder for add, subtract, shift-add multiply and restoring divide
// depends on rpn_pkg
//
// one item is worked on at a time; multiply and divide take 32 iterations of the shared adder
// a finished result waits in the output register while the next item is taken
// reset (synchronous, active low) empties the stack and clears the halt; stack memory is not
// cleared, entries above the stack count are never used

module rpn_stack_evaluator #(
    parameter int unsigned STACK_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] number
    input  logic [2:0]  i_s_axis_tuser,   // [2:0] action
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [31:0] value, [38:32] depth, [39] zero
    output logic [2:0]  o_m_axis_tuser,   // [2:0] status
    output logic        o_m_axis_tlast
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam rpn_pkg::t_count CAP = rpn_pkg::COUNT_W'(STACK_DEPTH);

    // stack memory
    rpn_pkg::t_value mem [STACK_DEPTH];
    rpn_pkg::t_value r_rd_data;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    rpn_pkg::t_value mem_wdata;
    logic            mem_re;
    logic [AW-1:0]   mem_raddr;

    // sequencer and datapath registers
    rpn_pkg::t_state  r_state, n_state;
    rpn_pkg::t_count  r_count, n_count;
    rpn_pkg::t_count  r_idx, n_idx;
    rpn_pkg::t_value  r_top, n_top;
    logic             r_halted, n_halted;
    rpn_pkg::t_action r_act, n_act;
    logic             r_under, n_under;
    logic             r_neg, n_neg;
    rpn_pkg::t_value  r_acc, n_acc;
    rpn_pkg::t_value  r_opa, n_opa;
    rpn_pkg::t_value  r_opb, n_opb;
    logic [rpn_pkg::STEP_W-1:0] r_step, n_step;
    rpn_pkg::t_value  r_res_value, n_res_value;
    rpn_pkg::t_status r_res_status, n_res_status;

    // output register
    logic             r_out_valid, n_out_valid;
    rpn_pkg::t_value  r_out_value, n_out_value;
    rpn_pkg::t_count  r_out_depth, n_out_depth;
    rpn_pkg::t_status r_out_status, n_out_status;
    logic             r_out_last, n_out_last;

    // combinational helpers
    logic             s_fire;
    logic             out_free;
    rpn_pkg::t_action in_action;
    rpn_pkg::t_value  in_number;
    rpn_pkg::t_value  top_value;
    rpn_pkg::t_value  op_a;
    rpn_pkg::t_value  op_b;
    rpn_pkg::t_value  abs_a;
    rpn_pkg::t_value  abs_b;
    rpn_pkg::t_count  cnt_m1;
    rpn_pkg::t_count  cnt_m2;
    rpn_pkg::t_count  idx_m1;
    logic [rpn_pkg::ADDER_W-1:0] add_x;
    logic [rpn_pkg::ADDER_W-1:0] add_y;
    logic                        add_sub;
    logic [rpn_pkg::ADDER_W-1:0] add_sum;
    logic [rpn_pkg::ADDER_W-1:0] rem_shift;

    // handshake and port unpacking
    assign o_s_axis_tready = (r_state == rpn_pkg::ST_IDLE);
    assign s_fire          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign in_action       = i_s_axis_tuser;
    assign in_number       = i_s_axis_tdata;

    // stack views and operands (missing operands read as all ones)
    assign top_value = (r_count == '0) ? '0 : r_top;
    assign op_a      = (r_count >= rpn_pkg::COUNT_W'(2)) ? r_rd_data : '1;
    assign op_b      = (r_count >= rpn_pkg::COUNT_W'(1)) ? r_top : '1;
    assign abs_a     = op_a[rpn_pkg::VALUE_W-1] ? ('0 - op_a) : op_a;
    assign abs_b     = op_b[rpn_pkg::VALUE_W-1] ? ('0 - op_b) : op_b;
    assign cnt_m1    = r_count - rpn_pkg::COUNT_W'(1);
    assign cnt_m2    = r_count - rpn_pkg::COUNT_W'(2);
    assign idx_m1    = r_idx - rpn_pkg::COUNT_W'(1);
    assign rem_shift = {r_acc, r_opa[rpn_pkg::VALUE_W-1]};

    // shared adder / subtractor
    assign add_sum = add_x + (add_sub ? ~add_y : add_y) + rpn_pkg::ADDER_W'(add_sub);

    // sequencer: next state, datapath and memory controls
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_top        = r_top;
        n_halted     = r_halted;
        n_act        = r_act;
        n_under      = r_under;
        n_neg        = r_neg;
        n_acc        = r_acc;
        n_opa        = r_opa;
        n_opb        = r_opb;
        n_step       = r_step;
        n_res_value  = r_res_value;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_value  = r_out_value;
        n_out_depth  = r_out_depth;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        mem_we       = 1'b0;
        mem_waddr    = r_count[AW-1:0];
        mem_wdata    = r_acc;
        mem_re       = 1'b0;
        mem_raddr    = cnt_m1[AW-1:0];
        add_x        = {1'b0, op_a};
        add_y        = {1'b0, op_b};
        add_sub      = 1'b0;

        unique case (r_state)
            rpn_pkg::ST_IDLE: begin
                if (s_fire) begin
                    priority if (r_halted) begin
                        n_res_value  = top_value;
                        n_res_status = rpn_pkg::STAT_HALTED;
                        n_state      = rpn_pkg::ST_EMIT;
                    end else begin
                        unique case (in_action)
                            rpn_pkg::ACT_PUSH: begin
                                if (r_count >= CAP) begin
                                    n_res_value  = top_value;
                                    n_res_status = rpn_pkg::STAT_OVERFLOW;
                                end else begin
                                    mem_we       = 1'b1;
                                    mem_wdata    = in_number;
                                    n_count      = r_count + rpn_pkg::COUNT_W'(1);
                                    n_top        = in_number;
                                    n_res_value  = in_number;
                                    n_res_status = rpn_pkg::STAT_OK;
                                end
                                n_state = rpn_pkg::ST_EMIT;
                            end
                            rpn_pkg::ACT_ADD, rpn_pkg::ACT_SUB,
                            rpn_pkg::ACT_MUL, rpn_pkg::ACT_DIV: begin
                                // fetch the left operand, the right one is held in r_top
                                n_act     = in_action;
                                mem_re    = 1'b1;
                                mem_raddr = cnt_m2[AW-1:0];
                                n_state   = rpn_pkg::ST_OPER;
                            end
                            rpn_pkg::ACT_DUMP: begin
                                if (r_count == '0) begin
                                    n_res_value  = '0;
                                    n_res_status = rpn_pkg::STAT_UNDERFLOW;
                                    n_state      = rpn_pkg::ST_EMIT;
                                end else begin
                                    n_idx   = r_count;
                                    n_state = rpn_pkg::ST_DUMP_RD;
                                end
                            end
                            default: begin
                                n_res_value  = top_value;
                                n_res_status = rpn_pkg::STAT_OK;
                                n_state      = rpn_pkg::ST_EMIT;
                            end
                        endcase
                    end
                end
            end

            rpn_pkg::ST_OPER: begin
                // pop both operands
                n_under = (r_count < rpn_pkg::COUNT_W'(2));
                n_count = (r_count >= rpn_pkg::COUNT_W'(2)) ? cnt_m2 : '0;
                n_step  = '0;
                unique case (r_act)
                    rpn_pkg::ACT_SUB: begin
                        add_sub = 1'b1;
                        n_acc   = add_sum[rpn_pkg::VALUE_W-1:0];
                        n_state = rpn_pkg::ST_PUSH_RES;
                    end
                    rpn_pkg::ACT_MUL: begin
                        n_acc   = '0;
                        n_opa   = op_a;
                        n_opb   = op_b;
                        n_state = rpn_pkg::ST_MUL;
                    end
                    rpn_pkg::ACT_DIV: begin
                        if (op_b == '0) begin
                            n_halted     = 1'b1;
                            n_res_status = rpn_pkg::STAT_DIVZERO;
                            n_state      = rpn_pkg::ST_ZREAD;
                        end else begin
                            n_acc   = '0;
                            n_opa   = abs_a;
                            n_opb   = abs_b;
                            n_neg   = op_a[rpn_pkg::VALUE_W-1] ^ op_b[rpn_pkg::VALUE_W-1];
                            n_state = rpn_pkg::ST_DIV;
                        end
                    end
                    default: begin
                        n_acc   = add_sum[rpn_pkg::VALUE_W-1:0];
                        n_state = rpn_pkg::ST_PUSH_RES;
                    end
                endcase
            end

            rpn_pkg::ST_MUL: begin
                // shift-add, one multiplier bit per cycle
                add_x = {1'b0, r_acc};
                add_y = {1'b0, r_opa};
                if (r_opb[0]) begin
                    n_acc = add_sum[rpn_pkg::VALUE_W-1:0];
                end
                n_opa  = r_opa << 1;
                n_opb  = r_opb >> 1;
                n_step = r_step + rpn_pkg::STEP_W'(1);
                if (r_step == rpn_pkg::STEP_LAST) begin
                    n_state = rpn_pkg::ST_PUSH_RES;
                end
            end

            rpn_pkg::ST_DIV: begin
                // restoring division on magnitudes, one quotient bit per cycle
                add_x   = rem_shift;
                add_y   = {1'b0, r_opb};
                add_sub = 1'b1;
                if (!add_sum[rpn_pkg::ADDER_W-1]) begin
                    n_acc = add_sum[rpn_pkg::VALUE_W-1:0];
                    n_opa = {r_opa[rpn_pkg::VALUE_W-2:0], 1'b1};
                end else begin
                    n_acc = rem_shift[rpn_pkg::VALUE_W-1:0];
                    n_opa = {r_opa[rpn_pkg::VALUE_W-2:0], 1'b0};
                end
                n_step = r_step + rpn_pkg::STEP_W'(1);
                if (r_step == rpn_pkg::STEP_LAST) begin
                    n_state = rpn_pkg::ST_DIV_FIX;
                end
            end

            rpn_pkg::ST_DIV_FIX: begin
                // apply the quotient sign
                add_x   = '0;
                add_y   = {1'b0, r_opa};
                add_sub = 1'b1;
                n_acc   = r_neg ? add_sum[rpn_pkg::VALUE_W-1:0] : r_opa;
                n_state = rpn_pkg::ST_PUSH_RES;
            end

            rpn_pkg::ST_PUSH_RES: begin
                mem_we       = 1'b1;
                mem_wdata    = r_acc;
                n_count      = r_count + rpn_pkg::COUNT_W'(1);
                n_top        = r_acc;
                n_res_value  = r_acc;
                n_res_status = r_under ? rpn_pkg::STAT_UNDERFLOW : rpn_pkg::STAT_OK;
                n_state      = rpn_pkg::ST_EMIT;
            end

            rpn_pkg::ST_ZREAD: begin
                // refetch the new top after the operands were dropped
                mem_re    = 1'b1;
                mem_raddr = cnt_m1[AW-1:0];
                n_state   = rpn_pkg::ST_ZTOP;
            end

            rpn_pkg::ST_ZTOP: begin
                n_top       = r_rd_data;
                n_res_value = (r_count == '0) ? '0 : r_rd_data;
                n_state     = rpn_pkg::ST_EMIT;
            end

            rpn_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = r_res_value;
                    n_out_depth  = r_count;
                    n_out_status = r_res_status;
                    n_out_last   = 1'b1;
                    n_state      = rpn_pkg::ST_IDLE;
                end
            end

            rpn_pkg::ST_DUMP_RD: begin
                mem_re    = 1'b1;
                mem_raddr = idx_m1[AW-1:0];
                n_state   = rpn_pkg::ST_DUMP_EMIT;
            end

            rpn_pkg::ST_DUMP_EMIT: begin
                // one entry per transfer, top first
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = r_rd_data;
                    n_out_depth  = r_count;
                    n_out_status = rpn_pkg::STAT_OK;
                    n_out_last   = (r_idx == rpn_pkg::COUNT_W'(1));
                    n_idx        = idx_m1;
                    n_state      = (r_idx == rpn_pkg::COUNT_W'(1)) ?
                                   rpn_pkg::ST_IDLE : rpn_pkg::ST_DUMP_RD;
                end
            end

            default: begin
                n_state = rpn_pkg::ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rpn_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_halted    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_halted    <= n_halted;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_top        <= n_top;
        r_act        <= n_act;
        r_under      <= n_under;
        r_neg        <= n_neg;
        r_acc        <= n_acc;
        r_opa        <= n_opa;
        r_opb        <= n_opb;
        r_step       <= n_step;
        r_res_value  <= n_res_value;
        r_res_status <= n_res_status;
        r_out_value  <= n_out_value;
        r_out_depth  <= n_out_depth;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    // stack memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_raddr];
        end
    end

    // result port
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_depth, r_out_value};
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tlast  = r_out_last;

    // stack never grows beyond its capacity
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP)
        else $error("stack count above capacity");

    // a halt holds until reset
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halt cleared without reset");

    // the last divide iteration always hands over to the sign fix
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rpn_pkg::ST_DIV && r_step == rpn_pkg::STEP_LAST)
        |=> (r_state == rpn_pkg::ST_DIV_FIX))
        else $error("divide sequence left early or late");

    // a halted or divide-by-zero result always ends its item
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == rpn_pkg::STAT_HALTED ||
                             o_m_axis_tuser == rpn_pkg::STAT_DIVZERO))
        |-> o_m_axis_tlast)
        else $error("fault result not marked last");

    // an accepted item always starts work
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire |=> (r_state != rpn_pkg::ST_IDLE))
        else $error("accepted item dropped");

endmodule

/* test/tb_top.sv */
// tb_top: self-checking bench for rpn_stack_evaluator, with a stream driver, a result
// monitor and a stack predictor that works out the expected results of every transfer
// depends on rpn_pkg and rpn_stack_evaluator
`timescale 1ns / 100ps

module tb_top;

    localparam int STACK_CAP = 64;
    localparam rpn_pkg::t_action ACT_NOP_6 = 3'd6;
    localparam rpn_pkg::t_action ACT_NOP_7 = 3'd7;

    typedef struct {
        rpn_pkg::t_action act;
        rpn_pkg::t_value  num;
    } t_calc_item;

    typedef struct {
        rpn_pkg::t_value  value;
        rpn_pkg::t_count  depth;
        rpn_pkg::t_status status;
        logic             last;
    } t_calc_result;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    t_calc_item   pending_items[$];
    t_calc_result expected_results[$];
    t_calc_item   next_item;
    t_calc_result want;

    // predictor state
    rpn_pkg::t_value stack_mem [STACK_CAP];
    int unsigned     stack_cnt = 0;
    bit              calc_halted = 1'b0;
    bit              short_pop;

    int n_total = 0;
    int n_accepted = 0;
    int n_errors = 0;

    rpn_stack_evaluator u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),   // [31:0] number
        .i_s_axis_tuser  (s_tuser),   // [2:0] action
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),   // [31:0] value, [38:32] depth, [39] zero
        .o_m_axis_tuser  (m_tuser),   // [2:0] status
        .o_m_axis_tlast  (m_tlast)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        n_errors++;
    endtask

    // ---------------------------------------------------------------- predictor

    function automatic rpn_pkg::t_value stack_top();
        return (stack_cnt == 0) ? rpn_pkg::t_value'(0) : stack_mem[stack_cnt-1];
    endfunction

    // pop one entry, a missing one reads as all ones and marks a short pop
    function automatic rpn_pkg::t_value take_entry();
        if (stack_cnt == 0) begin
            short_pop = 1'b1;
            return '1;
        end
        stack_cnt--;
        return stack_mem[stack_cnt];
    endfunction

    // signed quotient truncated toward zero, most negative by minus one wraps
    function automatic rpn_pkg::t_value signed_quot(input rpn_pkg::t_value lhs,
                                                    input rpn_pkg::t_value rhs);
        rpn_pkg::t_value mag_l;
        rpn_pkg::t_value mag_r;
        rpn_pkg::t_value q;
        mag_l = lhs[31] ? -lhs : lhs;
        mag_r = rhs[31] ? -rhs : rhs;
        q = mag_l / mag_r;
        return (lhs[31] ^ rhs[31]) ? -q : q;
    endfunction

    task automatic note_result(input rpn_pkg::t_value value, input rpn_pkg::t_status status,
                               input logic last);
        t_calc_result r;
        r.value  = value;
        r.depth  = rpn_pkg::t_count'(stack_cnt);
        r.status = status;
        r.last   = last;
        expected_results.push_back(r);
    endtask

    task automatic eval_item(input rpn_pkg::t_action act, input rpn_pkg::t_value num);
        rpn_pkg::t_value rhs;
        rpn_pkg::t_value lhs;
        rpn_pkg::t_value res;
        if (calc_halted) begin
            note_result(stack_top(), rpn_pkg::STAT_HALTED, 1'b1);
            return;
        end
        case (act)
            rpn_pkg::ACT_PUSH: begin
                if (stack_cnt >= STACK_CAP) begin
                    note_result(stack_top(), rpn_pkg::STAT_OVERFLOW, 1'b1);
                end else begin
                    stack_mem[stack_cnt] = num;
                    stack_cnt++;
                    note_result(stack_top(), rpn_pkg::STAT_OK, 1'b1);
                end
            end
            rpn_pkg::ACT_ADD, rpn_pkg::ACT_SUB, rpn_pkg::ACT_MUL, rpn_pkg::ACT_DIV: begin
                short_pop = 1'b0;
                rhs = take_entry();
                lhs = take_entry();
                if (act == rpn_pkg::ACT_DIV && rhs == 0) begin
                    // zero divisor wins over a short pop and halts the block
                    calc_halted = 1'b1;
                    note_result(stack_top(), rpn_pkg::STAT_DIVZERO, 1'b1);
                end else begin
                    case (act)
                        rpn_pkg::ACT_ADD: res = lhs + rhs;
                        rpn_pkg::ACT_SUB: res = lhs - rhs;
                        rpn_pkg::ACT_MUL: res = lhs * rhs;
                        default:          res = signed_quot(lhs, rhs);
                    endcase
                    stack_mem[stack_cnt] = res;
                    stack_cnt++;
                    note_result(stack_top(),
                                short_pop ? rpn_pkg::STAT_UNDERFLOW : rpn_pkg::STAT_OK, 1'b1);
                end
            end
            rpn_pkg::ACT_DUMP: begin
                if (stack_cnt == 0) begin
                    note_result('0, rpn_pkg::STAT_UNDERFLOW, 1'b1);
                end else begin
                    for (int i = stack_cnt; i > 0; i--)
                        note_result(stack_mem[i-1], rpn_pkg::STAT_OK, i == 1);
                end
            end
            default: note_result(stack_top(), rpn_pkg::STAT_OK, 1'b1);
        endcase
    endtask

    // ---------------------------------------------------------------- stimulus helpers

    task automatic add_item(input rpn_pkg::t_action act, input rpn_pkg::t_value num);
        t_calc_item it;
        it.act = act;
        it.num = num;
        pending_items.push_back(it);
    endtask

    function automatic rpn_pkg::t_value pick_number();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'hFFFF_FFFF;
            3: return 32'h8000_0000;
            4: return 32'h7FFF_FFFF;
            5, 6: return rpn_pkg::t_value'($urandom_range(0, 200)) - 32'd100;
            default: return $urandom;
        endcase
    endfunction

    // random add, subtract or multiply
    function automatic rpn_pkg::t_action pick_arith();
        return rpn_pkg::t_action'($urandom_range(rpn_pkg::ACT_ADD, rpn_pkg::ACT_MUL));
    endfunction

    // idle share of the sender or stall share of the receiver in the current phase
    function automatic int idle_pct(input bit sender);
        int phase;
        phase = (n_total == 0) ? 0 : (n_accepted * 4) / n_total;
        case (phase)
            0: return 0;
            1: return sender ? 45 : 0;
            2: return sender ? 0 : 45;
            default: return 24;
        endcase
    endfunction

    // ---------------------------------------------------------------- driver

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                eval_item(s_tuser, s_tdata);
                n_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_items.size() > 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
                    next_item = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_item.num;
                    s_tuser  <= next_item.act;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 99) >= idle_pct(1'b0));
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result value %h", m_tdata[31:0]));
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[31:0] !== want.value)
                    report_mismatch($sformatf("value %h, want %h", m_tdata[31:0], want.value));
                if (m_tdata[38:32] !== want.depth)
                    report_mismatch($sformatf("depth %0d, want %0d", m_tdata[38:32],
                                              want.depth));
                if (m_tdata[39] !== 1'b0)
                    report_mismatch("padding bit of result data not zero");
                if (m_tuser !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d", m_tuser, want.status));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("last %b, want %b", m_tlast, want.last));
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        int n_random;
        int run_len;
        int kind;
        rpn_pkg::t_value div_num;

        // directed: empty stack, wrap, most negative by minus one, truncation, no-ops
        add_item(rpn_pkg::ACT_DUMP, 32'd0);
        add_item(rpn_pkg::ACT_ADD, 32'hFFFF_FFFF);
        add_item(rpn_pkg::ACT_SUB, 32'd0);
        add_item(rpn_pkg::ACT_PUSH, 32'h7FFF_FFFF);
        add_item(rpn_pkg::ACT_PUSH, 32'd1);
        add_item(rpn_pkg::ACT_ADD, 32'd0);
        add_item(rpn_pkg::ACT_PUSH, 32'h8000_0000);
        add_item(rpn_pkg::ACT_PUSH, 32'hFFFF_FFFF);
        add_item(rpn_pkg::ACT_DIV, 32'd0);
        add_item(rpn_pkg::ACT_PUSH, 32'h8000_0000);
        add_item(rpn_pkg::ACT_PUSH, 32'hFFFF_FFFF);
        add_item(rpn_pkg::ACT_MUL, 32'd0);
        add_item(rpn_pkg::ACT_PUSH, -32'sd7);
        add_item(rpn_pkg::ACT_PUSH, 32'd2);
        add_item(rpn_pkg::ACT_DIV, 32'd0);
        add_item(rpn_pkg::ACT_PUSH, 32'd7);
        add_item(rpn_pkg::ACT_PUSH, -32'sd2);
        add_item(rpn_pkg::ACT_DIV, 32'd0);
        add_item(ACT_NOP_6, 32'hFFFF_FFFF);
        add_item(ACT_NOP_7, 32'h0);
        add_item(rpn_pkg::ACT_DUMP, 32'hFFFF_FFFF);

        // random part, mostly well-formed postfix fragments
        n_random = 0;
        while (n_random < 8) begin
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
                run_len = $urandom_range(1, 6);
                for (int i = 0; i < run_len; i++)
                    add_item(rpn_pkg::ACT_PUSH, pick_number());
                n_random += run_len;
            end else if (kind < 60) begin
                add_item(pick_arith(), $urandom);
                n_random++;
            end else if (kind < 75) begin
                // the add leaves room, so the pushed divisor is on top and non-zero
                add_item(rpn_pkg::ACT_ADD, $urandom);
                div_num = pick_number();
                add_item(rpn_pkg::ACT_PUSH, (div_num == 0) ? rpn_pkg::t_value'(1) : div_num);
                add_item(rpn_pkg::ACT_DIV, $urandom);
                n_random += 3;
            end else if (kind < 83) begin
                add_item(rpn_pkg::ACT_DUMP, $urandom);
                n_random++;
            end else if (kind < 90) begin
                add_item(rpn_pkg::t_action'($urandom_range(ACT_NOP_6, ACT_NOP_7)), $urandom);
                n_random++;
            end else begin
                // run of operators that may drain the stack into underflow
                run_len = $urandom_range(3, 8);
                for (int i = 0; i < run_len; i++)
                    add_item(pick_arith(), $urandom);
                n_random += run_len;
            end
        end

        // fill the stack past the top, then dump it whole; the stack ends full
        for (int i = 0; i < STACK_CAP + 1; i++)
            add_item(rpn_pkg::ACT_PUSH, pick_number());
        add_item(rpn_pkg::ACT_DUMP, $urandom);

        // random arithmetic that drains the full stack to one entry
        for (int i = 0; i < STACK_CAP - 1; i++)
            add_item(pick_arith(), $urandom);

        // make the single entry zero, then divide by it with one operand missing
        add_item(rpn_pkg::ACT_PUSH, 32'd0);
        add_item(rpn_pkg::ACT_MUL, 32'd0);
        add_item(rpn_pkg::ACT_DIV, 32'd0);
        // halted from here on
        add_item(rpn_pkg::ACT_PUSH, 32'd5);
        add_item(rpn_pkg::ACT_DUMP, 32'd0);
        add_item(rpn_pkg::ACT_ADD, 32'd0);
        add_item(ACT_NOP_7, 32'd0);
        n_total = pending_items.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted != n_total) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        if (n_errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

/* sim.f */
hdl/rpn_pkg.sv
hdl/rpn_stack_evaluator.sv
test/tb_top.sv
